>>> sv/kbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbs_pkg: shared types and codes of the keyframe bracket sampler
// Field widths, request and register codes, loop modes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package kbs_pkg;

  localparam int unsigned KEY_IDX_W  = 4;
  localparam int unsigned KEY_CNT_W  = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEAMLESS = 2'd2;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_RD_LAST   = 12'b0000_0000_0010,
    ST_RD_PEN    = 12'b0000_0000_0100,
    ST_RD_ONE    = 12'b0000_0000_1000,
    ST_RD_ZERO   = 12'b0000_0001_0000,
    ST_PERIOD    = 12'b0000_0010_0000,
    ST_DIV       = 12'b0000_0100_0000,
    ST_SEARCH    = 12'b0000_1000_0000,
    ST_SEG       = 12'b0001_0000_0000,
    ST_BLEND_CHK = 12'b0010_0000_0000,
    ST_FRAC      = 12'b0100_0000_0000,
    ST_OUT       = 12'b1000_0000_0000
  } kbs_state_e;

endpackage

>>> sv/kbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/keyframe_bracket_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_bracket_sampler: keyframe bracket search with looping
// Load items fill the keyframe time table; sample items give the bracketing
// keys, a saturated blend fraction and the loop count.
// Sequence: a load item writes the table directly; a sample item reads the
//   last, penultimate, second and first keys, then runs the bit-serial
//   divider for the period division, searches with one table read per key
//   step, and runs the same divider again for the blend division.
// Throughput: one item at a time; a finished result waits in the output
//   register while the next item is taken.
// Reset: loop mode, key count and loop count clear; the time table does not.
// ----------------------------------------------------------------------------
module keyframe_bracket_sampler #(
  parameter int unsigned MAX_KEYS  = 16,
  parameter int unsigned TIME_BITS = 31,
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned IN_BITS  = kbs_pkg::KEY_IDX_W + 2 * TIME_BITS,
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS = 2 * kbs_pkg::KEY_IDX_W + FRAC_BITS + TIME_BITS + 2,
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // key_index, key_time, play_time
  input  logic [IN_W-1:0]                 s_axis_tdata,
  // req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // first_key, second_key, blend_frac, loop_count, keys_present, time_error
  output logic [OUT_W-1:0]                m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [kbs_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [kbs_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned KW   = kbs_pkg::KEY_IDX_W;
  localparam int unsigned AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW   = $clog2(MAX_KEYS + 1);
  localparam int unsigned DW   = TIME_BITS + 1;
  localparam int unsigned SW   = TIME_BITS + 2;
  localparam int unsigned QW   = (TIME_BITS > FRAC_BITS) ? TIME_BITS : FRAC_BITS;
  localparam int unsigned CNTW = $clog2(QW + 1);

  kbs_pkg::kbs_state_e state_q, state_d;

  logic [kbs_pkg::MODE_W-1:0]    mode_q, mode_d;
  logic [kbs_pkg::KEY_CNT_W-1:0] kcount_q, kcount_d;
  logic [TIME_BITS-1:0]          loops_q, loops_d;
  logic                          out_valid_q, out_valid_d;
  logic [CNTW-1:0]               cnt_q, cnt_d;

  logic [TIME_BITS-1:0]  play_q, play_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  pen_q, pen_d;
  logic [TIME_BITS-1:0]  one_q, one_d;
  logic [TIME_BITS-1:0]  zero_q, zero_d;
  logic [TIME_BITS-1:0]  tfirst_q, tfirst_d;
  logic [TIME_BITS-1:0]  tsec_q, tsec_d;
  logic signed [SW-1:0]  period_q, period_d;
  logic signed [SW-1:0]  seg_q, seg_d;
  logic signed [SW-1:0]  off_q, off_d;
  logic [AW-1:0]         first_q, first_d;
  logic [AW-1:0]         second_q, second_d;
  logic [FRAC_BITS-1:0]  frac_q, frac_d;
  logic                  err_q, err_d;
  logic [DW-1:0]         div_r_q, div_r_d;
  logic [DW-1:0]         div_d_q, div_d_d;
  logic [QW-1:0]         div_q_q, div_q_d;

  logic [KW-1:0]         out_first_q, out_first_d;
  logic [KW-1:0]         out_second_q, out_second_d;
  logic [FRAC_BITS-1:0]  out_frac_q, out_frac_d;
  logic [TIME_BITS-1:0]  out_loops_q, out_loops_d;
  logic                  out_present_q, out_present_d;
  logic                  out_err_q, out_err_d;

  logic [KW-1:0]         in_idx;
  logic [TIME_BITS-1:0]  in_time;
  logic [TIME_BITS-1:0]  in_play;
  logic                  in_fire;
  logic                  ram_we;
  logic [AW-1:0]         raddr;
  logic [TIME_BITS-1:0]  rdata;

  logic [NW-1:0]         n;
  logic [NW-1:0]         lim;
  logic [AW-1:0]         n_m1;
  logic [AW-1:0]         n_m2;
  logic                  looping;
  logic                  seamless;

  logic [DW:0]           r2;
  logic [DW:0]           r2_diff;
  logic                  ge;
  logic [DW-1:0]         r_step;
  logic [QW-1:0]         q_step;

  logic                  in_range;
  logic                  more;
  logic signed [SW-1:0]  seg_calc;

  assign in_idx  = s_axis_tdata[KW-1:0];
  assign in_time = s_axis_tdata[KW +: TIME_BITS];
  assign in_play = s_axis_tdata[KW + TIME_BITS +: TIME_BITS];

  assign s_axis_tready = (state_q == kbs_pkg::ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ram_we        = in_fire && (s_axis_tuser == kbs_pkg::REQ_LOAD)
                         && (32'(in_idx) < MAX_KEYS);

  always_comb begin
    if (32'(kcount_q) > MAX_KEYS) begin
      n = NW'(MAX_KEYS);
    end else begin
      n = NW'(kcount_q);
    end
  end

  assign n_m1     = AW'(n - NW'(1));
  assign n_m2     = AW'(n - NW'(2));
  assign seamless = (mode_q == kbs_pkg::MODE_SEAMLESS);
  assign looping  = (mode_q == kbs_pkg::MODE_NORMAL) || seamless;
  assign lim      = seamless ? (n - NW'(1)) : (n - NW'(2));

  always_comb begin
    case (state_q)
      kbs_pkg::ST_RD_LAST: raddr = n_m1;
      kbs_pkg::ST_RD_PEN:  raddr = n_m2;
      kbs_pkg::ST_RD_ONE:  raddr = AW'(1);
      kbs_pkg::ST_DIV:     raddr = first_q + AW'(1);
      kbs_pkg::ST_SEARCH:  raddr = first_q + AW'(2);
      default:             raddr = '0;
    endcase
  end

  kbs_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_idx)),
    .wdata_i (in_time),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // one quotient bit per cycle
  assign r2      = {div_r_q, div_q_q[QW-1]};
  assign r2_diff = r2 - {1'b0, div_d_q};
  assign ge      = (r2 >= {1'b0, div_d_q});
  assign r_step  = ge ? r2_diff[DW-1:0] : r2[DW-1:0];
  assign q_step  = {div_q_q[QW-2:0], ge};

  assign in_range = (NW'(first_q) < lim);
  assign more     = in_range && ({1'b0, rdata} <= div_r_q);
  assign seg_calc = SW'({2'b00, tsec_q}) - SW'({2'b00, tfirst_q});

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    kcount_d      = kcount_q;
    loops_d       = loops_q;
    out_valid_d   = out_valid_q;
    cnt_d         = cnt_q;
    play_d        = play_q;
    last_d        = last_q;
    pen_d         = pen_q;
    one_d         = one_q;
    zero_d        = zero_q;
    tfirst_d      = tfirst_q;
    tsec_d        = tsec_q;
    period_d      = period_q;
    seg_d         = seg_q;
    off_d         = off_q;
    first_d       = first_q;
    second_d      = second_q;
    frac_d        = frac_q;
    err_d         = err_q;
    div_r_d       = div_r_q;
    div_d_d       = div_d_q;
    div_q_d       = div_q_q;
    out_first_d   = out_first_q;
    out_second_d  = out_second_q;
    out_frac_d    = out_frac_q;
    out_loops_d   = out_loops_q;
    out_present_d = out_present_q;
    out_err_d     = out_err_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_addr_i)
        kbs_pkg::CFG_LOOP_MODE: mode_d   = cfg_wdata_i[kbs_pkg::MODE_W-1:0];
        kbs_pkg::CFG_KEY_COUNT: kcount_d = cfg_wdata_i[kbs_pkg::KEY_CNT_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      kbs_pkg::ST_IDLE: begin
        if (in_fire && (s_axis_tuser == kbs_pkg::REQ_SAMPLE)) begin
          play_d   = in_play;
          first_d  = '0;
          second_d = '0;
          frac_d   = '0;
          err_d    = 1'b0;
          if (n < NW'(2)) begin
            state_d = kbs_pkg::ST_OUT;
          end else if (!looping && (loops_q != '0)) begin
            first_d  = n_m1;
            second_d = n_m1;
            state_d  = kbs_pkg::ST_OUT;
          end else begin
            state_d = kbs_pkg::ST_RD_LAST;
          end
        end
      end
      kbs_pkg::ST_RD_LAST: begin
        state_d = kbs_pkg::ST_RD_PEN;
      end
      kbs_pkg::ST_RD_PEN: begin
        last_d  = rdata;
        state_d = kbs_pkg::ST_RD_ONE;
      end
      kbs_pkg::ST_RD_ONE: begin
        pen_d   = rdata;
        state_d = kbs_pkg::ST_RD_ZERO;
      end
      kbs_pkg::ST_RD_ZERO: begin
        one_d = rdata;
        if (seamless) begin
          period_d = SW'({1'b0, last_q, 1'b0}) - SW'({2'b00, pen_q});
        end else begin
          period_d = SW'({2'b00, last_q});
        end
        state_d = kbs_pkg::ST_PERIOD;
      end
      kbs_pkg::ST_PERIOD: begin
        zero_d   = rdata;
        tfirst_d = rdata;
        if (period_q[SW-1] || (period_q == '0)) begin
          err_d    = 1'b1;
          first_d  = n_m1;
          second_d = n_m1;
          state_d  = kbs_pkg::ST_OUT;
        end else begin
          first_d = '0;
          div_r_d = '0;
          div_d_d = DW'(period_q);
          div_q_d = QW'(play_q);
          cnt_d   = CNTW'(QW);
          state_d = kbs_pkg::ST_DIV;
        end
      end
      kbs_pkg::ST_DIV: begin
        div_r_d = r_step;
        div_q_d = q_step;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          loops_d = q_step[TIME_BITS-1:0];
          state_d = kbs_pkg::ST_SEARCH;
        end
      end
      kbs_pkg::ST_SEARCH: begin
        if (more) begin
          first_d  = first_q + AW'(1);
          tfirst_d = rdata;
        end else begin
          if (in_range) begin
            tsec_d   = rdata;
            second_d = first_q + AW'(1);
          end else if (seamless) begin
            tsec_d   = zero_q;
            second_d = '0;
          end else begin
            tsec_d   = last_q;
            second_d = first_q + AW'(1);
          end
          state_d = kbs_pkg::ST_SEG;
        end
      end
      kbs_pkg::ST_SEG: begin
        if (seamless && seg_calc[SW-1]) begin
          seg_d = SW'({2'b00, one_q});
        end else begin
          seg_d = seg_calc;
        end
        off_d   = SW'({1'b0, div_r_q}) - SW'({2'b00, tfirst_q});
        state_d = kbs_pkg::ST_BLEND_CHK;
      end
      kbs_pkg::ST_BLEND_CHK: begin
        if (seg_q[SW-1] || (seg_q == '0)) begin
          err_d   = 1'b1;
          frac_d  = '0;
          state_d = kbs_pkg::ST_OUT;
        end else if (off_q[SW-1] || (off_q == '0)) begin
          frac_d  = '0;
          state_d = kbs_pkg::ST_OUT;
        end else if (off_q >= seg_q) begin
          frac_d  = {FRAC_BITS{1'b1}};
          state_d = kbs_pkg::ST_OUT;
        end else begin
          div_r_d = DW'(off_q);
          div_d_d = DW'(seg_q);
          div_q_d = '0;
          cnt_d   = CNTW'(FRAC_BITS);
          state_d = kbs_pkg::ST_FRAC;
        end
      end
      kbs_pkg::ST_FRAC: begin
        div_r_d = r_step;
        div_q_d = q_step;
        cnt_d   = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          frac_d  = q_step[FRAC_BITS-1:0];
          state_d = kbs_pkg::ST_OUT;
        end
      end
      kbs_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_first_d   = KW'(first_q);
          out_second_d  = KW'(second_q);
          out_frac_d    = frac_q;
          out_loops_d   = loops_q;
          out_present_d = (n != '0);
          out_err_d     = err_q;
          state_d       = kbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kbs_pkg::ST_IDLE;
      mode_q      <= kbs_pkg::MODE_NONE;
      kcount_q    <= '0;
      loops_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      kcount_q    <= kcount_d;
      loops_q     <= loops_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    play_q        <= play_d;
    last_q        <= last_d;
    pen_q         <= pen_d;
    one_q         <= one_d;
    zero_q        <= zero_d;
    tfirst_q      <= tfirst_d;
    tsec_q        <= tsec_d;
    period_q      <= period_d;
    seg_q         <= seg_d;
    off_q         <= off_d;
    first_q       <= first_d;
    second_q      <= second_d;
    frac_q        <= frac_d;
    err_q         <= err_d;
    div_r_q       <= div_r_d;
    div_d_q       <= div_d_d;
    div_q_q       <= div_q_d;
    out_first_q   <= out_first_d;
    out_second_q  <= out_second_d;
    out_frac_q    <= out_frac_d;
    out_loops_q   <= out_loops_d;
    out_present_q <= out_present_d;
    out_err_q     <= out_err_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_err_q, out_present_q, out_loops_q, out_frac_q,
                                 out_second_q, out_first_q});

  a_div_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbs_pkg::ST_DIV || state_q == kbs_pkg::ST_FRAC) |-> cnt_q != '0)
    else $error("divider running with an empty step count");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kbs_pkg::ST_DIV || state_q == kbs_pkg::ST_FRAC) |-> div_r_q < div_d_q)
    else $error("partial remainder not below divisor");

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == kbs_pkg::ST_SEARCH |-> NW'(first_q) <= lim)
    else $error("bracket search ran past its limit");

  a_err_frac_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> out_frac_q == '0)
    else $error("time error result carries a nonzero blend fraction");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyframe bracket sampler
// Fills the keyframe table through load items and checks each sample result
// against an in-bench bracket search. Covers every loop mode, small and
// oversized key counts, ascending, duplicate, unordered and zero tables, and
// random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import kbs_pkg::*;

  localparam int unsigned MAX_KEYS     = 16;
  localparam int unsigned TIME_BITS    = 31;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned IN_W         = 72;
  localparam int unsigned OUT_W        = 64;
  localparam longint      FRAC_MAX     = (longint'(1) << FRAC_BITS) - 1;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned ITEM_TARGET  = 1900;
  localparam int unsigned CALM_AFTER   = 1650;

  typedef struct packed {
    logic                 time_error;
    logic                 keys_present;
    logic [TIME_BITS-1:0] loop_count;
    logic [FRAC_BITS-1:0] blend_frac;
    logic [KEY_IDX_W-1:0] second_key;
    logic [KEY_IDX_W-1:0] first_key;
  } bracket_t;

  class keyframe_tracker;
    bit [TIME_BITS-1:0]  key_ms [MAX_KEYS];
    bit [TIME_BITS-1:0]  loops_done;
    bit [MODE_W-1:0]     mode;
    bit [KEY_CNT_W-1:0]  key_count;
    bracket_t            due_brackets [$];
    int unsigned         mismatches;
    int unsigned         samples_checked;
    int unsigned         loads_seen;

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      if (addr == CFG_LOOP_MODE) begin
        mode = data[MODE_W-1:0];
      end else begin
        key_count = data;
      end
    endfunction

    function longint ms(longint idx);
      return longint'(key_ms[idx]);
    endfunction

    function logic [FRAC_BITS-1:0] blend_of(longint off, longint seg, inout bit err);
      longint q;
      if (seg <= 0) begin
        err = 1'b1;
        return '0;
      end
      if (off <= 0) return '0;
      q = (off << FRAC_BITS) / seg;
      return (q > FRAC_MAX) ? '1 : q[FRAC_BITS-1:0];
    endfunction

    function bracket_t bracket_at(logic [TIME_BITS-1:0] play_ms);
      bracket_t r;
      longint   n, first, second, period, rem, seg, play;
      bit       err, looping;
      r       = '0;
      first   = 0;
      second  = 0;
      err     = 1'b0;
      play    = longint'(play_ms);
      n       = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
      looping = (mode == MODE_NORMAL) || (mode == MODE_SEAMLESS);
      if (n >= 2) begin
        if (!looping && loops_done != 0) begin
          first  = n - 1;
          second = n - 1;
        end else begin
          if (mode == MODE_SEAMLESS) period = 2 * ms(n - 1) - ms(n - 2);
          else period = ms(n - 1);
          if (period <= 0) begin
            err    = 1'b1;
            first  = n - 1;
            second = n - 1;
          end else begin
            rem        = play % period;
            loops_done = TIME_BITS'(play / period);
            if (mode == MODE_SEAMLESS) begin
              while (first != n - 1 && ms(first + 1) <= rem) first++;
              // wrap from the last key back to key 0
              second = (first == n - 1) ? 0 : first + 1;
              seg    = ms(second) - ms(first);
              if (seg < 0) seg = ms(1);
            end else begin
              while (first < n - 2 && ms(first + 1) <= rem) first++;
              second = first + 1;
              seg    = ms(second) - ms(first);
            end
            r.blend_frac = blend_of(rem - ms(first), seg, err);
          end
        end
      end
      r.first_key    = first[KEY_IDX_W-1:0];
      r.second_key   = second[KEY_IDX_W-1:0];
      r.loop_count   = loops_done;
      r.keys_present = (n >= 1);
      r.time_error   = err;
      return r;
    endfunction

    function void note_item(logic req, logic [KEY_IDX_W-1:0] idx,
                            logic [TIME_BITS-1:0] key_t, logic [TIME_BITS-1:0] play_t);
      if (req == REQ_LOAD) begin
        key_ms[idx] = key_t;
        loads_seen++;
      end else begin
        due_brackets.push_back(bracket_at(play_t));
      end
    endfunction

    function void compare_field(string name, logic [TIME_BITS-1:0] want,
                                logic [TIME_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bracket_t got);
      bracket_t want;
      if (due_brackets.size() == 0) begin
        $error("result with no sample pending: %h", got);
        mismatches++;
        return;
      end
      want = due_brackets.pop_front();
      samples_checked++;
      compare_field("first_key", want.first_key, got.first_key);
      compare_field("second_key", want.second_key, got.second_key);
      compare_field("blend_frac", want.blend_frac, got.blend_frac);
      compare_field("loop_count", want.loop_count, got.loop_count);
      compare_field("keys_present", want.keys_present, got.keys_present);
      compare_field("time_error", want.time_error, got.time_error);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic                  s_axis_tuser = REQ_LOAD;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = CFG_LOOP_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  keyframe_tracker    tracker = new;
  bit [TIME_BITS-1:0] planned_ms [MAX_KEYS];
  int unsigned        items_sent;
  int unsigned        settings_done;
  int unsigned        idle_pct = 25;
  int unsigned        stall_left;
  int unsigned        quiet_cycles;

  keyframe_bracket_sampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(1, 7);
    end
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tracker.note_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[34:4],
                        s_axis_tdata[65:35]);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(bracket_t'(m_axis_tdata[56:0]));
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_item(logic req, logic [KEY_IDX_W-1:0] idx,
                           logic [TIME_BITS-1:0] key_t, logic [TIME_BITS-1:0] play_t);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'b0, play_t, key_t, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_load(logic [KEY_IDX_W-1:0] idx, logic [TIME_BITS-1:0] key_t);
    planned_ms[idx] = key_t;
    send_item(REQ_LOAD, idx, key_t, TIME_BITS'($urandom));
  endtask

  task automatic send_sample(logic [TIME_BITS-1:0] play_t);
    send_item(REQ_SAMPLE, KEY_IDX_W'($urandom), TIME_BITS'($urandom), play_t);
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.due_brackets.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [MODE_W-1:0] mode, logic [KEY_CNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word   = {3'($urandom), mode};
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_LOOP_MODE;
    cfg_wdata_i <= mode_word;
    @(posedge clk_i);
    tracker.set_reg(CFG_LOOP_MODE, mode_word);
    cfg_addr_i  <= CFG_KEY_COUNT;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    tracker.set_reg(CFG_KEY_COUNT, count);
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  task automatic run_directed();
    send_sample('0);
    send_sample(TIME_MAX);
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (i == MAX_KEYS - 1) send_load(i, TIME_MAX);
      else send_load(i, TIME_BITS'(i * 100));
    end
    settle();
    write_settings(MODE_NORMAL, 1);
    send_sample(250);
    settle();
    write_settings(MODE_NORMAL, 4);
    send_sample('0);
    send_sample(150);
    send_sample(300);
    send_sample(1234567);
    settle();
    write_settings(MODE_SEAMLESS, 4);
    send_sample(350);
    send_sample(TIME_MAX);
    settle();
    write_settings(MODE_NONE, 4);
    send_sample(150);
    send_sample(1000);
    send_sample(50);
    settle();
    write_settings(MODE_RESERVED, 31);
    send_sample(10);
    settle();
    write_settings(MODE_NORMAL, 31);
    send_sample(5000);
    send_load(1, '0);
    settle();
    write_settings(MODE_NORMAL, 2);
    send_sample(77);
    settle();
    write_settings(MODE_SEAMLESS, 2);
    send_sample(77);
  endtask

  task automatic load_table(int unsigned shape);
    longint acc;
    longint step;
    acc = 0;
    case (shape)
      1: acc = $urandom_range(1, 200);
      4, 6: acc = 0;
      5: acc = TIME_MAX;
      default: acc = 0;
    endcase
    for (int i = 0; i < MAX_KEYS; i++) begin
      case (shape)
        0: step = $urandom_range(1, 60);
        1: step = $urandom_range(1, 1000);
        2: step = $urandom_range(0, 3);
        3: step = $urandom_range(1, 1 << 26);
        5: step = -longint'($urandom_range(0, 100));
        default: step = 0;
      endcase
      if (shape == 4) acc = longint'(TIME_BITS'($urandom));
      else if (i != 0) acc = acc + step;
      if (acc > TIME_MAX) acc = TIME_MAX;
      if (acc < 0) acc = 0;
      send_load(i, TIME_BITS'(acc));
    end
  endtask

  function automatic logic [TIME_BITS-1:0] pick_play(logic [KEY_CNT_W-1:0] count);
    longint n;
    longint span;
    n    = (count > MAX_KEYS) ? MAX_KEYS : count;
    span = 3 * longint'(planned_ms[(n >= 1) ? n - 1 : 0]) + 64;
    if (span > TIME_MAX) span = TIME_MAX;
    case ($urandom_range(0, 19))
      0: return TIME_BITS'($urandom);
      1: return planned_ms[$urandom_range(0, MAX_KEYS - 1)];
      2: return TIME_MAX;
      3: return '0;
      default: return TIME_BITS'($urandom_range(0, span));
    endcase
  endfunction

  task automatic run_random();
    logic [MODE_W-1:0]    mode;
    logic [KEY_CNT_W-1:0] count;
    int unsigned          samples;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (items_sent >= CALM_AFTER) idle_pct = 0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = MODE_NORMAL;
        4, 5, 6, 7: mode = MODE_SEAMLESS;
        8: mode = MODE_NONE;
        default: mode = MODE_RESERVED;
      endcase
      case ($urandom_range(0, 19))
        0: count = 0;
        1: count = 1;
        2: count = $urandom_range(MAX_KEYS + 1, 31);
        default: count = $urandom_range(2, MAX_KEYS);
      endcase
      write_settings(mode, count);
      load_table($urandom_range(0, 6));
      samples = $urandom_range(15, 50);
      repeat (samples) begin
        if ($urandom_range(0, 19) == 0) begin
          send_load(KEY_IDX_W'($urandom), TIME_BITS'($urandom));
        end else begin
          send_sample(pick_play(count));
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (tracker.due_brackets.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d sample results after %0d table loads under %0d register settings",
             tracker.samples_checked, tracker.loads_seen, settings_done);
    $display("loop modes none, normal, seamless and reserved; key counts 0 to 31");
    if (tracker.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> keyframe_bracket_sampler.f
sv/kbs_pkg.sv
sv/kbs_ram.sv
sv/keyframe_bracket_sampler.sv
tb/tb.sv
